/* src/sslseq_pkg.sv */
// Shared types and constants for the startup status LED sequencer.
// Used by the step logic and the top level.
package sslseq_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned STATUS_W  = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 20;

    typedef enum logic [1:0] {
        PH_BOOT = 2'd0,
        PH_CAL  = 2'd1,
        PH_GLOW = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_RUN = 3'd0,
        CFG_FAST_ON   = 3'd1,
        CFG_FAST_OFF  = 3'd2,
        CFG_SLOW_ON   = 3'd3,
        CFG_SLOW_OFF  = 3'd4,
        CFG_GLOW      = 3'd5,
        CFG_TIMEOUT   = 3'd6
    } t_cfg_idx;

    localparam logic [TICK_W-1:0]    RST_FAST_ON  = 16'd100;
    localparam logic [TICK_W-1:0]    RST_FAST_OFF = 16'd100;
    localparam logic [TICK_W-1:0]    RST_SLOW_ON  = 16'd500;
    localparam logic [TICK_W-1:0]    RST_SLOW_OFF = 16'd500;
    localparam logic [TICK_W-1:0]    RST_GLOW     = 16'd2000;
    localparam logic [ELAPSED_W-1:0] RST_TIMEOUT  = 20'd60000;

    typedef struct packed {
        logic                 first_run_mode;
        logic [TICK_W-1:0]    fast_on_ticks;
        logic [TICK_W-1:0]    fast_off_ticks;
        logic [TICK_W-1:0]    slow_on_ticks;
        logic [TICK_W-1:0]    slow_off_ticks;
        logic [TICK_W-1:0]    glow_ticks;
        logic [ELAPSED_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic                 lit_half;
        logic [TICK_W-1:0]    period_count;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 timeout_seen;
    } t_state;

    typedef struct packed {
        logic       led_level;
        logic [1:0] phase_code;
        logic       clear_flag_pulse;
        logic       timed_out;
    } t_result;

endpackage

/* src/sslseq_in_if.sv */
// Input channel: one millisecond tick carrying the sensor status bits.
// Depends on nothing.
interface sslseq_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] sensor_status;

    modport source (output valid, output sensor_status, input ready);
    modport sink   (input valid, input sensor_status, output ready);
endinterface

/* src/sslseq_out_if.sv */
// Output channel: LED level, phase code, clear request and timeout flag.
// Depends on nothing.
interface sslseq_out_if;
    logic       valid;
    logic       ready;
    logic       led_level;
    logic [1:0] phase_code;
    logic       clear_flag_pulse;
    logic       timed_out;

    modport source (output valid, output led_level, output phase_code,
                    output clear_flag_pulse, output timed_out, input ready);
    modport sink   (input valid, input led_level, input phase_code,
                    input clear_flag_pulse, input timed_out, output ready);
endinterface

/* src/startup_status_led_sequencer.sv */
// Top level of the startup status LED sequencer: config registers, state, result register.
// Depends on sslseq_pkg, sslseq_in_if, sslseq_out_if and sslseq_step.
//
//  channel  | dir | payload                                            | handshake
//  i_in     | in  | sensor_status[3:0]                                 | valid/ready
//  o_out    | out | led_level, phase_code[1:0], clear_flag_pulse, timed_out | valid/ready
//  cfg      | in  | i_cfg_we, i_cfg_idx[2:0], i_cfg_data[19:0]         | write only
//
// One tick is accepted per cycle unless the output stalls; its result is registered.
// The per-tick step logic is a single combinational pass between state and result register.
// Synchronous active-low reset loads register defaults and the booting state.
// A stalled result holds; a new tick is taken in the same cycle the result drains.
module startup_status_led_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sslseq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sslseq_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    sslseq_in_if.sink                          i_in,
    sslseq_out_if.source                       o_out
);
    import sslseq_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_take;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    sslseq_step u_step (
        .i_cfg    (r_cfg),
        .i_cur    (r_state),
        .i_status (i_in.sensor_status),
        .o_nxt    (n_state),
        .o_res    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_run_mode <= 1'b0;
            r_cfg.fast_on_ticks  <= RST_FAST_ON;
            r_cfg.fast_off_ticks <= RST_FAST_OFF;
            r_cfg.slow_on_ticks  <= RST_SLOW_ON;
            r_cfg.slow_off_ticks <= RST_SLOW_OFF;
            r_cfg.glow_ticks     <= RST_GLOW;
            r_cfg.timeout_ticks  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_RUN: r_cfg.first_run_mode <= i_cfg_data[0];
                CFG_FAST_ON:   r_cfg.fast_on_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_FAST_OFF:  r_cfg.fast_off_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_SLOW_ON:   r_cfg.slow_on_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_SLOW_OFF:  r_cfg.slow_off_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_GLOW:      r_cfg.glow_ticks     <= i_cfg_data[TICK_W-1:0];
                CFG_TIMEOUT:   r_cfg.timeout_ticks  <= i_cfg_data[ELAPSED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_BOOT;
            r_state.lit_half     <= 1'b1;
            r_state.period_count <= '0;
            r_state.elapsed_ms   <= '0;
            r_state.timeout_seen <= 1'b0;
            r_out_valid          <= 1'b0;
        end else if (in_take) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.led_level        = r_res.led_level;
    assign o_out.phase_code       = r_res.phase_code;
    assign o_out.clear_flag_pulse = r_res.clear_flag_pulse;
    assign o_out.timed_out        = r_res.timed_out;

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.timeout_seen |=> r_state.timeout_seen)
        else $error("timeout flag dropped");

    a_pulse_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clear_flag_pulse) |->
        (o_out.phase_code == PH_GLOW || o_out.phase_code == PH_DONE))
        else $error("clear request outside glow entry");

    a_done_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.phase_code == PH_DONE) |-> !o_out.led_level)
        else $error("LED lit after sequence done");

    a_done_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DONE) |=> (r_state.phase == PH_DONE))
        else $error("left done phase");

endmodule

/* src/sslseq_step.sv */
// Per-tick next-state and result logic of the LED sequencer.
// Depends on sslseq_pkg.
module sslseq_step (
    input  sslseq_pkg::t_cfg               i_cfg,
    input  sslseq_pkg::t_state             i_cur,
    input  logic [sslseq_pkg::STATUS_W-1:0] i_status,
    output sslseq_pkg::t_state             o_nxt,
    output sslseq_pkg::t_result            o_res
);
    import sslseq_pkg::*;

    always_comb begin
        logic                 start;
        logic                 expired;
        logic                 one_ready;
        logic                 both_cal;
        t_phase               ph;
        t_phase               code;
        logic                 lit;
        logic                 led;
        logic                 pulse;
        logic                 seen;
        logic [TICK_W-1:0]    pc;
        logic [TICK_W-1:0]    limit;
        logic [TICK_W:0]      pc_inc;
        logic [ELAPSED_W-1:0] el;

        start     = ((i_cur.phase == PH_BOOT) || (i_cur.phase == PH_CAL)) &&
                    i_cur.lit_half && (i_cur.period_count == '0);
        expired   = (i_cur.elapsed_ms >= i_cfg.timeout_ticks);
        one_ready = (i_status[1:0] != 2'b00);
        both_cal  = (i_status[3:2] == 2'b11);
        ph        = i_cur.phase;
        lit       = i_cur.lit_half;
        pc        = i_cur.period_count;
        seen      = i_cur.timeout_seen;
        pulse     = 1'b0;
        led       = 1'b0;
        limit     = '0;

        // period start: leave booting, then possibly calibrating, on the same tick
        if (start && (ph == PH_BOOT) && i_cfg.first_run_mode) begin
            if (one_ready || expired) begin
                if (!one_ready) seen = 1'b1;
                ph = PH_CAL;
            end
        end
        if (start && ((ph == PH_CAL) || ((ph == PH_BOOT) && !i_cfg.first_run_mode))) begin
            if (both_cal || expired) begin
                if (!both_cal) seen = 1'b1;
                ph    = PH_GLOW;
                pulse = i_cfg.first_run_mode;
                pc    = '0;
                lit   = 1'b1;
            end
        end

        code   = ph;
        pc_inc = {1'b0, pc} + {{TICK_W{1'b0}}, 1'b1};

        case (ph)
            PH_BOOT, PH_CAL: begin
                led = lit;
                if (ph == PH_BOOT) begin
                    limit = lit ? i_cfg.fast_on_ticks : i_cfg.fast_off_ticks;
                end else begin
                    limit = lit ? i_cfg.slow_on_ticks : i_cfg.slow_off_ticks;
                end
                if (pc_inc >= {1'b0, limit}) begin
                    pc  = '0;
                    lit = ~lit;
                end else begin
                    pc = pc_inc[TICK_W-1:0];
                end
            end
            PH_GLOW: begin
                if (i_cfg.glow_ticks == '0) begin
                    ph   = PH_DONE;
                    code = PH_DONE;
                end else begin
                    led = 1'b1;
                    if (pc_inc >= {1'b0, i_cfg.glow_ticks}) begin
                        pc = '0;
                        ph = PH_DONE;
                    end else begin
                        pc = pc_inc[TICK_W-1:0];
                    end
                end
            end
            default: begin
                led = 1'b0;
            end
        endcase

        el = (i_cur.elapsed_ms != '1) ? (i_cur.elapsed_ms + ELAPSED_W'(1))
                                      : i_cur.elapsed_ms;

        o_nxt.phase        = ph;
        o_nxt.lit_half     = lit;
        o_nxt.period_count = pc;
        o_nxt.elapsed_ms   = el;
        o_nxt.timeout_seen = seen;

        o_res.led_level        = led;
        o_res.phase_code       = code;
        o_res.clear_flag_pulse = pulse;
        o_res.timed_out        = seen;
    end

endmodule

/* tb/sv/tb_startup_status_led_sequencer.sv */
// Self-checking testbench for the startup status LED sequencer: a tick-by-tick predictor
// in a scoreboard class checks every LED result under random handshake stalls.
// Depends on sslseq_pkg, sslseq_in_if, sslseq_out_if and the block's top level.
module tb_startup_status_led_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import sslseq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    class led_status_board;
        t_cfg                 cfg;
        t_phase               phase;
        logic                 lit_half;
        logic [TICK_W-1:0]    period_count;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 timeout_seen;
        t_result              pending_leds[$];
        int                   errors;

        function new();
            cfg.first_run_mode = 1'b0;
            cfg.fast_on_ticks  = RST_FAST_ON;
            cfg.fast_off_ticks = RST_FAST_OFF;
            cfg.slow_on_ticks  = RST_SLOW_ON;
            cfg.slow_off_ticks = RST_SLOW_OFF;
            cfg.glow_ticks     = RST_GLOW;
            cfg.timeout_ticks  = RST_TIMEOUT;
            phase        = PH_BOOT;
            lit_half     = 1'b1;
            period_count = '0;
            elapsed_ms   = '0;
            timeout_seen = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                CFG_FIRST_RUN: cfg.first_run_mode = d[0];
                CFG_FAST_ON:   cfg.fast_on_ticks  = d[TICK_W-1:0];
                CFG_FAST_OFF:  cfg.fast_off_ticks = d[TICK_W-1:0];
                CFG_SLOW_ON:   cfg.slow_on_ticks  = d[TICK_W-1:0];
                CFG_SLOW_OFF:  cfg.slow_off_ticks = d[TICK_W-1:0];
                CFG_GLOW:      cfg.glow_ticks     = d[TICK_W-1:0];
                CFG_TIMEOUT:   cfg.timeout_ticks  = d[ELAPSED_W-1:0];
                default: ;
            endcase
        endfunction

        function bit at_period_start();
            return (phase == PH_BOOT || phase == PH_CAL) && lit_half && period_count == '0;
        endfunction

        function int pending();
            return pending_leds.size();
        endfunction

        function void note_tick(logic [STATUS_W-1:0] status);
            t_result           r;
            logic              boot_ready;
            logic              cond;
            logic              expired;
            logic              settled;
            logic [TICK_W:0]   cnt;
            logic [TICK_W-1:0] lim;
            r = '0;
            settled = 1'b0;
            // cascade: a phase left at period start falls into the next one
            for (int k = 0; k < 3; k++) begin
                if (!settled) begin
                    if (!at_period_start()) begin
                        settled = 1'b1;
                    end else begin
                        boot_ready = (phase == PH_BOOT) && cfg.first_run_mode;
                        cond = boot_ready ? |status[1:0] : &status[3:2];
                        expired = elapsed_ms >= cfg.timeout_ticks;
                        if (!cond && !expired) begin
                            settled = 1'b1;
                        end else begin
                            if (!cond) timeout_seen = 1'b1;
                            if (boot_ready) begin
                                phase = PH_CAL;
                            end else begin
                                phase = PH_GLOW;
                                r.clear_flag_pulse = cfg.first_run_mode;
                                period_count = '0;
                                lit_half = 1'b1;
                            end
                        end
                    end
                end
            end

            r.phase_code = phase;
            if (phase == PH_BOOT || phase == PH_CAL) begin
                r.led_level = lit_half;
                if (phase == PH_BOOT) begin
                    lim = lit_half ? cfg.fast_on_ticks : cfg.fast_off_ticks;
                end else begin
                    lim = lit_half ? cfg.slow_on_ticks : cfg.slow_off_ticks;
                end
                cnt = {1'b0, period_count} + 17'd1;
                if (cnt >= {1'b0, lim}) begin
                    period_count = '0;
                    lit_half = ~lit_half;
                end else begin
                    period_count = cnt[TICK_W-1:0];
                end
            end else if (phase == PH_GLOW) begin
                if (cfg.glow_ticks == '0) begin
                    phase = PH_DONE;
                    r.phase_code = PH_DONE;
                    r.led_level = 1'b0;
                end else begin
                    r.led_level = 1'b1;
                    cnt = {1'b0, period_count} + 17'd1;
                    if (cnt >= {1'b0, cfg.glow_ticks}) begin
                        period_count = '0;
                        phase = PH_DONE;
                    end else begin
                        period_count = cnt[TICK_W-1:0];
                    end
                end
            end

            if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 20'd1;
            r.timed_out = timeout_seen;
            pending_leds.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_leds.size() == 0) begin
                $error("result with no tick outstanding: phase_code %0d", got.phase_code);
                errors++;
            end else begin
                want = pending_leds.pop_front();
                if (got.led_level !== want.led_level) begin
                    $error("led_level: expected %0d, got %0d", want.led_level, got.led_level);
                    errors++;
                end
                if (got.phase_code !== want.phase_code) begin
                    $error("phase_code: expected %0d, got %0d", want.phase_code, got.phase_code);
                    errors++;
                end
                if (got.clear_flag_pulse !== want.clear_flag_pulse) begin
                    $error("clear_flag_pulse: expected %0d, got %0d",
                           want.clear_flag_pulse, got.clear_flag_pulse);
                    errors++;
                end
                if (got.timed_out !== want.timed_out) begin
                    $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    bit                   tx_steady;
    bit                   rx_steady;
    int unsigned          cycle_count = 0;
    led_status_board      leds;

    sslseq_in_if  in_ch ();
    sslseq_out_if out_ch ();

    startup_status_led_sequencer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(4, 30));
    endfunction

    function automatic logic [TICK_W-1:0] pick_half();
        int r;
        r = int'($urandom_range(0, 19));
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return 16'd1;
        return 16'($urandom_range(2, 6));
    endfunction

    function automatic logic [TICK_W-1:0] pick_glow();
        int r;
        r = int'($urandom_range(0, 3));
        if (r == 0) return '0;
        if (r == 1) return 16'd1;
        return 16'($urandom_range(2, 40));
    endfunction

    // random away from period starts, non-exiting at them
    function automatic logic [STATUS_W-1:0] pick_stay_status();
        logic [STATUS_W-1:0] s;
        s = 4'($urandom_range(0, 15));
        if (leds.at_period_start()) begin
            if (leds.phase == PH_BOOT && leds.cfg.first_run_mode) begin
                s[1:0] = 2'b00;
            end else if (&s[3:2]) begin
                s[$urandom_range(2, 3)] = 1'b0;
            end
        end
        return s;
    endfunction

    // receive side: hold ready low for random stretches
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_steady) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.led_level        = out_ch.led_level;
            got.phase_code       = out_ch.phase_code;
            got.clear_flag_pulse = out_ch.clear_flag_pulse;
            got.timed_out        = out_ch.timed_out;
            leds.check_result(got);
        end
    end

    task automatic send_tick(logic [STATUS_W-1:0] s);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sensor_status <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        leds.note_tick(s);
    endtask

    task automatic run_blink(int n);
        repeat (n) send_tick(pick_stay_status());
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (leds.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        leds.set_reg(idx, d);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic retime(t_cfg_idx on_idx, t_cfg_idx off_idx);
        quiesce();
        write_reg(on_idx, 20'(pick_half()));
        write_reg(off_idx, 20'(pick_half()));
        end_writes();
    endtask

    initial begin
        int                  path;
        int                  guard;
        logic [STATUS_W-1:0] s;
        leds = new();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_FIRST_RUN;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.sensor_status <= '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default registers; only the first tick is a period start
        send_tick(4'h0);
        send_tick(4'hC);
        send_tick(4'hF);
        send_tick(4'h3);
        send_tick(4'h5);
        send_tick(4'hA);

        quiesce();
        write_reg(CFG_FIRST_RUN, 20'd0);
        write_reg(CFG_FAST_ON, 20'd0);
        write_reg(CFG_FAST_OFF, 20'd1);
        write_reg(CFG_SLOW_ON, 20'hFFFF);
        write_reg(CFG_SLOW_OFF, 20'd0);
        write_reg(CFG_GLOW, 20'hFFFF);
        write_reg(CFG_TIMEOUT, 20'hFFFFF);
        end_writes();
        run_blink(12);

        // booting, normal mode
        for (int b = 0; b < 5; b++) begin
            retime(CFG_FAST_ON, CFG_FAST_OFF);
            if (b == 2) begin
                quiesce();
                write_reg(CFG_TIMEOUT, 20'($urandom_range(leds.elapsed_ms + 5000, 20'hFFFFF)));
                end_writes();
            end
            run_blink(100);
        end

        // booting, first-run mode, with the mode dropped for one stretch
        quiesce();
        write_reg(CFG_FIRST_RUN, 20'd1);
        end_writes();
        for (int b = 0; b < 4; b++) begin
            retime(CFG_FAST_ON, CFG_FAST_OFF);
            if (b == 1 || b == 2) begin
                quiesce();
                write_reg(CFG_FIRST_RUN, (b == 1) ? 20'd0 : 20'd1);
                end_writes();
            end
            run_blink(100);
        end

        quiesce();
        write_reg(CFG_FAST_ON, 20'($urandom_range(1, 3)));
        write_reg(CFG_FAST_OFF, 20'($urandom_range(0, 3)));
        write_reg(CFG_SLOW_ON, 20'($urandom_range(0, 4)));
        write_reg(CFG_SLOW_OFF, 20'($urandom_range(0, 4)));
        write_reg(CFG_GLOW, 20'(pick_glow()));
        write_reg(CFG_TIMEOUT, 20'hFFFFF);
        end_writes();

        path = int'($urandom_range(0, 2));
        guard = 0;
        if (path == 0) begin
            // ready and calibrated together: booting through calibrating into glow at once
            while (leds.phase == PH_BOOT && guard < 5000) begin
                s = 4'($urandom_range(0, 15));
                if (leds.at_period_start()) s = {2'b11, 2'($urandom_range(1, 3))};
                send_tick(s);
                guard++;
            end
        end else if (path == 2) begin
            // expire while booting
            quiesce();
            write_reg(CFG_TIMEOUT, 20'($urandom_range(0, leds.elapsed_ms)));
            end_writes();
            while (leds.phase == PH_BOOT && guard < 5000) begin
                s = 4'($urandom_range(0, 15));
                if (leds.at_period_start()) s[1:0] = 2'b00;
                send_tick(s);
                guard++;
            end
        end else begin
            while (leds.phase == PH_BOOT && guard < 5000) begin
                s = 4'($urandom_range(0, 15));
                if (leds.at_period_start()) begin
                    s[1:0] = 2'($urandom_range(1, 3));
                    if (&s[3:2]) s[$urandom_range(2, 3)] = 1'b0;
                end
                send_tick(s);
                guard++;
            end
            for (int b = 0; b < 4; b++) begin
                retime(CFG_SLOW_ON, CFG_SLOW_OFF);
                if (b == 1 || b == 3) begin
                    quiesce();
                    write_reg(CFG_FIRST_RUN, 20'($urandom_range(0, 1)));
                    end_writes();
                end
                run_blink(100);
            end
            quiesce();
            write_reg(CFG_SLOW_ON, 20'($urandom_range(0, 4)));
            write_reg(CFG_SLOW_OFF, 20'($urandom_range(0, 4)));
            if ($urandom_range(0, 1) == 1) begin
                // expire while calibrating; a met condition still wins
                write_reg(CFG_TIMEOUT, ($urandom_range(0, 3) == 0) ? 20'd0 :
                          20'(leds.elapsed_ms + $urandom_range(0, 30)));
                end_writes();
                while (leds.phase == PH_CAL && guard < 5000) begin
                    send_tick(4'($urandom_range(0, 15)));
                    guard++;
                end
            end else begin
                end_writes();
                while (leds.phase == PH_CAL && guard < 5000) begin
                    s = pick_stay_status();
                    if (leds.at_period_start() && $urandom_range(0, 2) == 0) s[3:2] = 2'b11;
                    send_tick(s);
                    guard++;
                end
            end
        end

        // glow, then done
        repeat (400) send_tick(4'($urandom_range(0, 15)));
        quiesce();
        write_reg(CFG_FIRST_RUN, 20'($urandom_range(0, 1)));
        write_reg(CFG_FAST_ON, 20'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_FAST_OFF, 20'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_SLOW_ON, 20'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_SLOW_OFF, 20'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_GLOW, 20'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_TIMEOUT, 20'($urandom_range(0, 20'hFFFFF)));
        end_writes();
        repeat (400) send_tick(4'($urandom_range(0, 15)));

        quiesce();
        repeat (10) @(negedge i_clk);
        if (leds.pending() != 0) begin
            $error("%0d results never arrived", leds.pending());
            leds.errors++;
        end
        if (leds.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/sslseq_pkg.sv
src/sslseq_in_if.sv
src/sslseq_out_if.sv
src/sslseq_step.sv
src/startup_status_led_sequencer.sv
tb/sv/tb_startup_status_led_sequencer.sv
